// ----- src/current_spike_homing_controller_top_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the current-spike homing controller
// Shared concurrent assertion forms, all clocked by clk.
// ---------------------------------------------------------------------------
`ifndef CURRENT_SPIKE_HOMING_CONTROLLER_TOP_DEFINES_SVH
`define CURRENT_SPIKE_HOMING_CONTROLLER_TOP_DEFINES_SVH

// Checked only outside reset.
`define CSHC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define CSHC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/cshc_pkg.sv -----
// ---------------------------------------------------------------------------
// cshc_pkg
// Types, constants and helpers shared by the homing controller modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package cshc_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 18;

  localparam logic [CfgIdxW-1:0] RegSingleLimit = 3'd0;
  localparam logic [CfgIdxW-1:0] RegIgnoreCount = 3'd1;
  localparam logic [CfgIdxW-1:0] RegHomeVelocity = 3'd2;
  localparam logic [CfgIdxW-1:0] RegCurThreshold = 3'd3;
  localparam logic [CfgIdxW-1:0] RegUnmonVelocity = 3'd4;
  localparam logic [CfgIdxW-1:0] RegUnmonExtra = 3'd5;

  localparam logic [9:0] SkipMax = 10'd1023;

  localparam logic FuncFeedback = 1'b0;
  localparam logic FuncSwitch = 1'b1;

  localparam logic ModeVelocity = 1'b0;
  localparam logic ModePosition = 1'b1;

  typedef struct packed {
    logic               single_limit_mode;
    logic [7:0]         ignore_count;
    logic signed [17:0] home_velocity;
    logic [15:0]        current_threshold;
    logic signed [17:0] unmonitored_velocity;
    logic [7:0]         unmonitored_extra;
  } cfg_t;

  typedef struct packed {
    logic               func;
    logic signed [31:0] position;
    logic signed [15:0] drive_current;
    logic               home_switch;
    logic               safe_start;
  } item_t;

  typedef struct packed {
    logic               cmd_valid;
    logic               cmd_mode;
    logic signed [31:0] setpoint;
    logic               is_homing;
    logic               is_ready;
    logic signed [31:0] home_position;
  } result_t;

  // Magnitude of a - b, exact in 33 bits.
  function automatic logic [32:0] abs_diff(input logic signed [31:0] a,
                                           input logic signed [31:0] b);
    logic signed [32:0] d;
    d = 33'(a) - 33'(b);
    abs_diff = d[32] ? 33'(-d) : 33'(d);
  endfunction

  function automatic logic [36:0] times_ten(input logic [32:0] x);
    times_ten = {1'b0, x, 3'b000} + {3'b000, x, 1'b0};
  endfunction

  function automatic logic signed [31:0] sext18(input logic signed [17:0] v);
    sext18 = {{14{v[17]}}, v};
  endfunction

endpackage

// ----- src/cshc_cfg.sv -----
// ---------------------------------------------------------------------------
// cshc_cfg
// Configuration register file, written through a plain write port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cshc_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [cshc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [cshc_pkg::CfgDataW-1:0] cfg_data,
  output cshc_pkg::cfg_t                cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.single_limit_mode    <= 1'b0;
      cfg.ignore_count         <= 8'd5;
      cfg.home_velocity        <= 18'sd1000;
      cfg.current_threshold    <= 16'd100;
      cfg.unmonitored_velocity <= 18'sd9000;
      cfg.unmonitored_extra    <= 8'd75;
    end else if (cfg_we) begin
      case (cfg_index)
        cshc_pkg::RegSingleLimit:   cfg.single_limit_mode    <= cfg_data[0];
        cshc_pkg::RegIgnoreCount:   cfg.ignore_count         <= cfg_data[7:0];
        cshc_pkg::RegHomeVelocity:  cfg.home_velocity        <= cfg_data;
        cshc_pkg::RegCurThreshold:  cfg.current_threshold    <= cfg_data[15:0];
        cshc_pkg::RegUnmonVelocity: cfg.unmonitored_velocity <= cfg_data;
        cshc_pkg::RegUnmonExtra:    cfg.unmonitored_extra    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- src/cshc_core.sv -----
// ---------------------------------------------------------------------------
// cshc_core
// Homing state and the per-item decision logic; state advances on fire.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cshc_core (
  input  logic              clk,
  input  logic              rst,
  input  cshc_pkg::cfg_t    cfg,
  input  logic              fire,
  input  cshc_pkg::item_t   item,
  output cshc_pkg::result_t result
);

  logic               homing_flag, homing_flag_next;
  logic               ready_flag, ready_flag_next;
  logic               prev_switch, prev_switch_next;
  logic               unmonitored_flag, unmonitored_flag_next;
  logic [9:0]         skip_counter, skip_counter_next;
  logic signed [31:0] upper_limit, upper_limit_next;
  logic signed [31:0] lower_limit, lower_limit_next;
  logic signed [31:0] center_position, center_position_next;

  logic               near;
  logic [15:0]        cur_mag;
  logic               spike;
  logic [9:0]         cnt_inc;
  logic [8:0]         unmon_target;
  logic signed [32:0] mid_sum;
  logic signed [32:0] mid_adj;
  logic signed [31:0] hvel_ext;

  // Within ten percent of either limit, measured against the center distance.
  assign near =
      (cshc_pkg::times_ten(cshc_pkg::abs_diff(item.position, upper_limit)) <
       {4'b0000, cshc_pkg::abs_diff(center_position, upper_limit)}) ||
      (cshc_pkg::times_ten(cshc_pkg::abs_diff(item.position, lower_limit)) <
       {4'b0000, cshc_pkg::abs_diff(center_position, lower_limit)});

  assign cur_mag = item.drive_current[15] ? 16'(-item.drive_current)
                                          : 16'(item.drive_current);
  assign spike = cur_mag > cfg.current_threshold;
  assign cnt_inc = (skip_counter != cshc_pkg::SkipMax) ? skip_counter + 10'd1 : skip_counter;
  assign unmon_target = {1'b0, cfg.ignore_count} + {1'b0, cfg.unmonitored_extra};
  assign hvel_ext = cshc_pkg::sext18(cfg.home_velocity);

  // Midpoint rounded toward zero: bias negative sums by one before the shift.
  assign mid_sum = 33'(upper_limit) + 33'(item.position);
  assign mid_adj = mid_sum + {32'd0, mid_sum[32]};

  always_comb begin
    homing_flag_next      = homing_flag;
    ready_flag_next       = ready_flag;
    prev_switch_next      = prev_switch;
    unmonitored_flag_next = unmonitored_flag;
    skip_counter_next     = skip_counter;
    upper_limit_next      = upper_limit;
    lower_limit_next      = lower_limit;
    center_position_next  = center_position;
    result.cmd_valid      = 1'b0;
    result.cmd_mode       = cshc_pkg::ModeVelocity;
    result.setpoint       = 32'sd0;

    if (item.func == cshc_pkg::FuncSwitch) begin
      if (item.home_switch && !prev_switch) begin
        homing_flag_next = 1'b1;
        upper_limit_next = 32'sd0;
        lower_limit_next = 32'sd0;
        result.cmd_valid = 1'b1;
        if (cfg.single_limit_mode && !item.safe_start) begin
          unmonitored_flag_next = 1'b1;
          result.setpoint = cshc_pkg::sext18(cfg.unmonitored_velocity);
        end else begin
          result.setpoint = hvel_ext;
        end
      end
      if (!item.home_switch) begin
        homing_flag_next = 1'b0;
        if (cfg.single_limit_mode) begin
          result.cmd_valid = 1'b1;
        end
      end
      prev_switch_next = item.home_switch;
    end else begin
      if (upper_limit != 32'sd0 && lower_limit != 32'sd0 && !near) begin
        ready_flag_next = 1'b1;
      end
      if (homing_flag) begin
        ready_flag_next = 1'b0;
        skip_counter_next = cnt_inc;
        if (cnt_inc >= {2'b00, cfg.ignore_count}) begin
          if (cfg.single_limit_mode && unmonitored_flag) begin
            if (cnt_inc == {1'b0, unmon_target}) begin
              result.cmd_valid      = 1'b1;
              result.setpoint       = hvel_ext;
              skip_counter_next     = 10'd0;
              unmonitored_flag_next = 1'b0;
            end
          end else if (spike && upper_limit == 32'sd0) begin
            // First hard stop: reverse, or finish in single-limit mode.
            result.cmd_valid = 1'b1;
            result.setpoint  = 32'sd0 - hvel_ext;
            if (cfg.single_limit_mode) begin
              result.setpoint       = 32'sd0;
              lower_limit_next      = item.position;
              homing_flag_next      = 1'b0;
              unmonitored_flag_next = 1'b0;
            end
            upper_limit_next  = item.position;
            skip_counter_next = 10'd0;
          end else if (spike && lower_limit == 32'sd0) begin
            lower_limit_next     = item.position;
            center_position_next = mid_adj[32:1];
            result.cmd_valid     = 1'b1;
            result.cmd_mode      = cshc_pkg::ModePosition;
            result.setpoint      = mid_adj[32:1];
            homing_flag_next     = 1'b0;
          end
        end
      end else if (ready_flag && near) begin
        result.cmd_valid = 1'b1;
      end
    end

    result.is_homing     = homing_flag_next;
    result.is_ready      = ready_flag_next;
    result.home_position = center_position_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      homing_flag      <= 1'b0;
      ready_flag       <= 1'b0;
      prev_switch      <= 1'b0;
      unmonitored_flag <= 1'b0;
      skip_counter     <= 10'd0;
      upper_limit      <= 32'sd0;
      lower_limit      <= 32'sd0;
      center_position  <= 32'sd0;
    end else if (fire) begin
      homing_flag      <= homing_flag_next;
      ready_flag       <= ready_flag_next;
      prev_switch      <= prev_switch_next;
      unmonitored_flag <= unmonitored_flag_next;
      skip_counter     <= skip_counter_next;
      upper_limit      <= upper_limit_next;
      lower_limit      <= lower_limit_next;
      center_position  <= center_position_next;
    end
  end

endmodule

// ----- src/current_spike_homing_controller_top.sv -----
// ---------------------------------------------------------------------------
// current_spike_homing_controller_top
// Path: an accepted item is held in the input register, then its result is
//   captured in the result register; a stalled output keeps it in the first.
// Throughput: one item per cycle unless the output stalls, set by the single pass through cshc_core.
// Reset: synchronous, active high; clears both stages, homing state and
//   restores the configuration register defaults.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "current_spike_homing_controller_top_defines.svh"

module current_spike_homing_controller_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [cshc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [cshc_pkg::CfgDataW-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          func,
  input  logic signed [31:0]            position,
  input  logic signed [15:0]            drive_current,
  input  logic                          home_switch,
  input  logic                          safe_start,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          cmd_valid,
  output logic                          cmd_mode,
  output logic signed [31:0]            setpoint,
  output logic                          is_homing,
  output logic                          is_ready,
  output logic signed [31:0]            home_position
);

  cshc_pkg::cfg_t    cfg;
  cshc_pkg::item_t   s1_item;
  logic              s1_valid;
  logic              advance;
  cshc_pkg::result_t step_result;
  cshc_pkg::result_t out_result;

  cshc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // An item moves on when the result register is empty or being drained.
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item.func          <= func;
      s1_item.position      <= position;
      s1_item.drive_current <= drive_current;
      s1_item.home_switch   <= home_switch;
      s1_item.safe_start    <= safe_start;
    end
  end

  cshc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .fire   (advance),
    .item   (s1_item),
    .result (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= step_result;
    end
  end

  assign cmd_valid     = out_result.cmd_valid;
  assign cmd_mode      = out_result.cmd_mode;
  assign setpoint      = out_result.setpoint;
  assign is_homing     = out_result.is_homing;
  assign is_ready      = out_result.is_ready;
  assign home_position = out_result.home_position;

  `CSHC_ASSERT(a_advance_fills_out, advance |=> out_valid, "processed item did not reach output")
  `CSHC_ASSERT(a_in_fills_stage, (in_valid && in_ready) |=> s1_valid, "accepted item was lost")
  `CSHC_ASSERT(a_move_cmd, (out_valid && cmd_mode) |-> (cmd_valid && !is_homing), "bad move")
  `CSHC_ASSERT_ALWAYS(a_reset_empty, rst |=> (!out_valid && !s1_valid), "not empty after reset")

endmodule
